// ===== rtl/scct_pkg.sv =====
`default_nettype none
package scct_pkg;
    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int DIFF_W   = 25;
    localparam int SQ_W     = 50;
    localparam int DOT_W    = 52;
    localparam int LEN_W    = 51;
    localparam int DIST_W   = 52;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd1280;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
    } seg_item_t;

    typedef struct packed {
        logic                      hit;
        logic                      zero_length;
        logic signed [COORD_W-1:0] closest_x;
        logic signed [COORD_W-1:0] closest_y;
    } hit_item_t;
endpackage
`default_nettype wire

// ===== rtl/scct_if.sv =====
`default_nettype none
interface scct_seg_if;
    logic                valid;
    logic                ready;
    scct_pkg::seg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface scct_hit_if;
    logic                valid;
    logic                ready;
    scct_pkg::hit_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/scct_divider.sv =====
`default_nettype none
// restoring divider: one quotient digit (0 to 2) per stage, 26 stages; quotient of |d|*dot/len2
module scct_divider
(
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [scct_pkg::COORD_W:0]       mag_in,
    input  wire logic [scct_pkg::LEN_W-1:0]       num_in,
    input  wire logic [scct_pkg::LEN_W-1:0]       den_in,
    output logic      [scct_pkg::COORD_W+1:0]     quot,
    output logic                                  round_up
);
    localparam int STEPS = scct_pkg::COORD_W + 2;
    localparam int RW = scct_pkg::LEN_W + 1;

    logic [STEPS-1:0]             mag_reg  [STEPS];
    logic [scct_pkg::LEN_W-1:0]   num_reg  [STEPS];
    logic [scct_pkg::LEN_W-1:0]   den_reg  [STEPS];
    logic [RW-1:0]                rem_reg  [STEPS+1];
    logic [STEPS-1:0]             q_reg    [STEPS+1];
    logic [RW-1:0]                rem_next [STEPS];
    logic [STEPS-1:0]             q_next   [STEPS];

    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            logic [RW:0] t;
            logic        b;
            b = mag_reg[i][STEPS-1-i];
            t = {rem_reg[i], 1'b0} + (b ? {2'b0, num_reg[i]} : '0);
            // r < den and num < den, so t < 3*den: at most two subtractions
            if (t >= {1'b0, den_reg[i], 1'b0})
            begin
                rem_next[i] = RW'(t - {1'b0, den_reg[i], 1'b0});
                q_next[i]   = {q_reg[i][STEPS-2:0], 1'b0} + STEPS'(2);
            end
            else if (t >= {2'b0, den_reg[i]})
            begin
                rem_next[i] = RW'(t - {2'b0, den_reg[i]});
                q_next[i]   = {q_reg[i][STEPS-2:0], 1'b0} + STEPS'(1);
            end
            else
            begin
                rem_next[i] = RW'(t);
                q_next[i]   = {q_reg[i][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= {1'b0, mag_in};
            num_reg[0] <= num_in;
            den_reg[0] <= den_in;
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i+1] <= rem_next[i];
                q_reg[i+1]   <= q_next[i];
                if (i + 1 < STEPS)
                begin
                    mag_reg[i+1] <= mag_reg[i];
                    num_reg[i+1] <= num_reg[i];
                    den_reg[i+1] <= den_reg[i];
                end
            end
        end
    end

    logic [scct_pkg::LEN_W-1:0] den_last_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_last_reg <= den_reg[STEPS-1];
        end
    end

    assign quot     = q_reg[STEPS];
    assign round_up = ({rem_reg[STEPS], 1'b0} >= {2'b0, den_last_reg});
endmodule
`default_nettype wire

// ===== rtl/segment_circle_collision_test.sv =====
`default_nettype none
// Segment/circle test: the closest point of segment A-B to center C, and a hit
// flag when it lies within the radius (never for a zero-length segment). One item
// per cycle while the output is not stalled; an item passes through four front
// stages, two parallel dividers of an input register and 26 quotient stages for
// the interior projection, and three back stages. The whole pipeline advances
// only while the output register is empty or being taken.
module segment_circle_collision_test
#(
    parameter int COORD_FRAC_BITS = 8
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    scct_seg_if.sink                            in_item,
    scct_hit_if.source                          out_item,
    input  wire logic                           cfg_we,
    input  wire logic [scct_pkg::RADIUS_W-1:0]  cfg_wdata
);
    localparam int DIV_LAT = scct_pkg::COORD_W + 3;
    localparam int LAT = 4 + DIV_LAT + 3;
    localparam int CW = scct_pkg::COORD_W;
    localparam int DW = scct_pkg::DIFF_W;
    localparam logic [scct_pkg::RADIUS_W-1:0] RADIUS_RST =
        scct_pkg::RADIUS_W'(5 << COORD_FRAC_BITS);

    logic [scct_pkg::RADIUS_W-1:0] radius_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    assign en = !out_item.valid || out_item.ready;
    assign in_item.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            vld_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], in_item.valid};
            end
        end
    end

    // stage 1: differences
    logic signed [CW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, wx1_reg, wy1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= in_item.data.seg_start_x;
            ay1_reg <= in_item.data.seg_start_y;
            bx1_reg <= in_item.data.seg_end_x;
            by1_reg <= in_item.data.seg_end_y;
            cx1_reg <= in_item.data.center_x;
            cy1_reg <= in_item.data.center_y;
            dx1_reg <= DW'(in_item.data.seg_end_x) - DW'(in_item.data.seg_start_x);
            dy1_reg <= DW'(in_item.data.seg_end_y) - DW'(in_item.data.seg_start_y);
            wx1_reg <= DW'(in_item.data.center_x) - DW'(in_item.data.seg_start_x);
            wy1_reg <= DW'(in_item.data.center_y) - DW'(in_item.data.seg_start_y);
        end
    end

    // stage 2: products
    logic signed [CW-1:0] ax2_reg, ay2_reg, bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic signed [scct_pkg::SQ_W-1:0] pxx_reg, pyy_reg;
    logic [scct_pkg::SQ_W-1:0] qxx_reg, qyy_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax2_reg <= ax1_reg; ay2_reg <= ay1_reg;
            bx2_reg <= bx1_reg; by2_reg <= by1_reg;
            cx2_reg <= cx1_reg; cy2_reg <= cy1_reg;
            dx2_reg <= dx1_reg; dy2_reg <= dy1_reg;
            pxx_reg <= scct_pkg::SQ_W'(wx1_reg * dx1_reg);
            pyy_reg <= scct_pkg::SQ_W'(wy1_reg * dy1_reg);
            qxx_reg <= scct_pkg::SQ_W'(dx1_reg * dx1_reg);
            qyy_reg <= scct_pkg::SQ_W'(dy1_reg * dy1_reg);
        end
    end

    // stage 3: dot and len2
    logic signed [CW-1:0] ax3_reg, ay3_reg, bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic signed [scct_pkg::DOT_W-1:0] dot3_reg;
    logic [scct_pkg::LEN_W-1:0] len3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax3_reg <= ax2_reg; ay3_reg <= ay2_reg;
            bx3_reg <= bx2_reg; by3_reg <= by2_reg;
            cx3_reg <= cx2_reg; cy3_reg <= cy2_reg;
            dx3_reg <= dx2_reg; dy3_reg <= dy2_reg;
            dot3_reg <= scct_pkg::DOT_W'(pxx_reg) + scct_pkg::DOT_W'(pyy_reg);
            len3_reg <= scct_pkg::LEN_W'(qxx_reg) + scct_pkg::LEN_W'(qyy_reg);
        end
    end

    // stage 4: classify
    logic signed [CW-1:0] ax4_reg, ay4_reg, bx4_reg, by4_reg, cx4_reg, cy4_reg;
    logic dxn4_reg, dyn4_reg, zero4_reg, lo4_reg, hi4_reg;
    logic [DW-1:0] mx4_reg, my4_reg;
    logic [scct_pkg::LEN_W-1:0] num4_reg, den4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax4_reg <= ax3_reg; ay4_reg <= ay3_reg;
            bx4_reg <= bx3_reg; by4_reg <= by3_reg;
            cx4_reg <= cx3_reg; cy4_reg <= cy3_reg;
            dxn4_reg <= dx3_reg[DW-1];
            dyn4_reg <= dy3_reg[DW-1];
            mx4_reg <= dx3_reg[DW-1] ? DW'(-dx3_reg) : DW'(dx3_reg);
            my4_reg <= dy3_reg[DW-1] ? DW'(-dy3_reg) : DW'(dy3_reg);
            zero4_reg <= (len3_reg == '0);
            lo4_reg <= dot3_reg <= 0;
            hi4_reg <= !dot3_reg[scct_pkg::DOT_W-1]
                && (dot3_reg >= $signed({1'b0, len3_reg}));
            num4_reg <= scct_pkg::LEN_W'(dot3_reg);
            den4_reg <= len3_reg;
        end
    end

    logic [CW+1:0] qx, qy;
    logic rux, ruy;
    scct_divider u_div_x
    (
        .clk(clk), .en(en), .mag_in(mx4_reg),
        .num_in(num4_reg), .den_in(den4_reg), .quot(qx), .round_up(rux)
    );
    scct_divider u_div_y
    (
        .clk(clk), .en(en), .mag_in(my4_reg),
        .num_in(num4_reg), .den_in(den4_reg), .quot(qy), .round_up(ruy)
    );

    // side delay line matching the dividers
    localparam int SW = 6 * CW + 5;
    logic [SW-1:0] side_reg [DIV_LAT];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {ax4_reg, ay4_reg, bx4_reg, by4_reg, cx4_reg, cy4_reg,
                            dxn4_reg, dyn4_reg, zero4_reg, lo4_reg, hi4_reg};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    logic signed [CW-1:0] sax, say, sbx, sby, scx, scy;
    logic sdxn, sdyn, szero, slo, shi;
    assign {sax, say, sbx, sby, scx, scy, sdxn, sdyn, szero, slo, shi} = side_reg[DIV_LAT-1];

    // stage A: closest point
    logic signed [CW-1:0] px_reg, py_reg, cxa_reg, cya_reg;
    logic zero_a_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [CW+1:0] ox, oy;
            ox = qx + (CW+2)'(rux);
            oy = qy + (CW+2)'(ruy);
            cxa_reg <= scx; cya_reg <= scy;
            zero_a_reg <= szero;
            if (szero || slo)
            begin
                px_reg <= sax; py_reg <= say;
            end
            else if (shi)
            begin
                px_reg <= sbx; py_reg <= sby;
            end
            else
            begin
                px_reg <= CW'(sdxn ? sax - CW'(ox) : sax + CW'(ox));
                py_reg <= CW'(sdyn ? say - CW'(oy) : say + CW'(oy));
            end
        end
    end

    // stage B: error squares
    logic signed [CW-1:0] pxb_reg, pyb_reg;
    logic zero_b_reg;
    logic [scct_pkg::SQ_W-1:0] exx_reg, eyy_reg;
    logic [2*scct_pkg::RADIUS_W-1:0] rr_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic signed [DW-1:0] ex, ey;
            ex = DW'(cxa_reg) - DW'(px_reg);
            ey = DW'(cya_reg) - DW'(py_reg);
            pxb_reg <= px_reg; pyb_reg <= py_reg;
            zero_b_reg <= zero_a_reg;
            exx_reg <= scct_pkg::SQ_W'(ex * ex);
            eyy_reg <= scct_pkg::SQ_W'(ey * ey);
            rr_reg <= (2*scct_pkg::RADIUS_W)'(radius_reg * radius_reg);
        end
    end

    // stage C: compare into output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item.data.closest_x <= pxb_reg;
            out_item.data.closest_y <= pyb_reg;
            out_item.data.zero_length <= zero_b_reg;
            out_item.data.hit <= !zero_b_reg &&
                ((scct_pkg::DIST_W'(exx_reg) + scct_pkg::DIST_W'(eyy_reg))
                 <= scct_pkg::DIST_W'(rr_reg));
        end
    end

    assign out_item.valid = vld_reg[LAT-1];
endmodule
`default_nettype wire

// ===== tb/sv/scct_tb_if.sv =====
interface scct_tb_clk_if;
    logic clk;
endinterface

// ===== tb/sv/segment_circle_collision_test_tb.sv =====
module segment_circle_collision_test_tb;
    localparam int LATENCY     = 34;
    localparam int WATCH_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [scct_pkg::RADIUS_W-1:0] cfg_wdata;

    scct_tb_clk_if clk_if();
    scct_seg_if seg_ch();
    scct_hit_if hit_ch();

    assign clk = clk_if.clk;

    segment_circle_collision_test i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_item(seg_ch.sink),
        .out_item(hit_ch.source),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    logic [scct_pkg::RADIUS_W-1:0] radius_q;
    scct_pkg::hit_item_t expected_hits[$];
    bit failed;
    bit quiet_phase;
    int idle_cycles;
    int stall_pct;

    initial
    begin
        clk_if.clk = 1'b0;
        forever
        begin
            #2 clk_if.clk = ~clk_if.clk;
        end
    end

    function automatic longint round_wide(longint d, longint num, longint den);
        logic [127:0] m;
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] r;
        m = (d < 0) ? -d : d;
        prod = m * num;
        q = prod / den;
        r = prod % den;
        if (2 * r >= den)
            q++;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic scct_pkg::hit_item_t closest_point(scct_pkg::seg_item_t s,
                                                          logic [scct_pkg::RADIUS_W-1:0] rad);
        scct_pkg::hit_item_t h;
        longint ax, ay, bx, by, cx, cy, dx, dy, px, py, ex, ey, dotp, len2, rr;
        ax = s.seg_start_x;
        ay = s.seg_start_y;
        bx = s.seg_end_x;
        by = s.seg_end_y;
        cx = s.center_x;
        cy = s.center_y;
        dx = bx - ax;
        dy = by - ay;
        h = '0;
        if (dx == 0 && dy == 0)
        begin
            h.zero_length = 1'b1;
            px = ax;
            py = ay;
        end
        else
        begin
            dotp = (cx - ax) * dx + (cy - ay) * dy;
            len2 = dx * dx + dy * dy;
            if (dotp <= 0)
            begin
                px = ax;
                py = ay;
            end
            else if (dotp >= len2)
            begin
                px = bx;
                py = by;
            end
            else
            begin
                // m*num stays below 2^73, split through 128-bit math
                px = ax + round_wide(dx, dotp, len2);
                py = ay + round_wide(dy, dotp, len2);
            end
            ex = cx - px;
            ey = cy - py;
            rr = longint'(rad) * longint'(rad);
            h.hit = ((ex * ex + ey * ey) <= rr);
        end
        h.closest_x = px[scct_pkg::COORD_W-1:0];
        h.closest_y = py[scct_pkg::COORD_W-1:0];
        return h;
    endfunction

    task automatic send_seg(scct_pkg::seg_item_t s);
        while (stall_pct > 0 && $urandom_range(99) < stall_pct)
        begin
            seg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seg_ch.valid <= 1'b1;
        seg_ch.data  <= s;
        @(posedge clk);
        while (!seg_ch.ready)
            @(posedge clk);
        expected_hits = {expected_hits, closest_point(s, radius_q)};
    endtask

    task automatic drain;
        seg_ch.valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_radius(logic [scct_pkg::RADIUS_W-1:0] r);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
        radius_q = r;
    endtask

    function automatic scct_pkg::seg_item_t mk(int ax, int ay, int bx, int by, int cx, int cy);
        scct_pkg::seg_item_t s;
        s.seg_start_x = scct_pkg::COORD_W'(ax);
        s.seg_start_y = scct_pkg::COORD_W'(ay);
        s.seg_end_x   = scct_pkg::COORD_W'(bx);
        s.seg_end_y   = scct_pkg::COORD_W'(by);
        s.center_x    = scct_pkg::COORD_W'(cx);
        s.center_y    = scct_pkg::COORD_W'(cy);
        return s;
    endfunction

    function automatic logic [scct_pkg::COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return scct_pkg::COORD_W'($urandom());
            1: return scct_pkg::COORD_W'($urandom_range(4096) - 2048);
            2:
            begin
                if ($urandom_range(1) != 0)
                    return scct_pkg::COORD_W'(24'h7fffff - $urandom_range(3));
                else
                    return scct_pkg::COORD_W'(24'h800000 + $urandom_range(3));
            end
            default: return scct_pkg::COORD_W'($urandom_range(200) - 100);
        endcase
    endfunction

    task automatic test_directed;
        int mx;
        int mn;
        mx = 8388607;
        mn = -8388608;
        send_seg(mk(0, 0, 2560, 0, 1280, 1280));
        send_seg(mk(0, 0, 2560, 0, 1280, 1281));
        send_seg(mk(0, 0, 2560, 0, -100, 0));
        send_seg(mk(0, 0, 2560, 0, 4000, 10));
        send_seg(mk(100, 200, 100, 200, 100, 200));
        send_seg(mk(mx, mx, mx, mx, mn, mn));
        send_seg(mk(mn, mn, mx, mx, 0, 0));
        send_seg(mk(mn, mx, mx, mn, mx, mx));
        send_seg(mk(mx, mn, mn, mx, mn, mn));
        send_seg(mk(mn, mn, mx, mn, 0, mx));
        send_seg(mk(0, 0, 3, 0, 1, 5));
        send_seg(mk(0, 0, -3, 0, -1, 5));
        send_seg(mk(0, 0, 2, 0, 1, 0));
        send_seg(mk(0, 0, -2, 0, -1, 0));
        send_seg(mk(0, 0, 7, 3, 5, -2));
        send_seg(mk(-1, -1, 1, 1, -1, 1));
        send_seg(mk(mx, 0, mn, 0, 0, mx));
        send_seg(mk(0, mx, 0, mn, mx, 0));
    endtask

    task automatic test_random(int n);
        scct_pkg::seg_item_t s;
        int mode;
        for (int i = 0; i < n; i++)
        begin
            quiet_phase = (i >= n / 2 && i < n / 2 + 150);
            stall_pct = quiet_phase ? 0 : 24;
            mode = int'($urandom_range(3));
            s.seg_start_x = rand_coord(mode);
            s.seg_start_y = rand_coord(mode);
            s.seg_end_x   = rand_coord(mode);
            s.seg_end_y   = rand_coord(mode);
            s.center_x    = rand_coord(mode);
            s.center_y    = rand_coord(mode);
            if ($urandom_range(19) == 0)
            begin
                s.seg_end_x = s.seg_start_x;
                s.seg_end_y = s.seg_start_y;
            end
            send_seg(s);
        end
        stall_pct = 24;
        quiet_phase = 1'b0;
    endtask

    task automatic test_radius_settings;
        write_radius(23'd0);
        test_random(150);
        write_radius(23'h7fffff);
        test_random(150);
        write_radius(23'd1);
        test_directed();
        write_radius(scct_pkg::RADIUS_RESET);
    endtask

    // result side
    initial
    begin
        scct_pkg::hit_item_t exp_h;
        hit_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hit_ch.valid && hit_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected item: %p", hit_ch.data);
                    failed = 1'b1;
                end
                else
                begin
                    exp_h = expected_hits.pop_front();
                    if (hit_ch.data.hit !== exp_h.hit)
                    begin
                        $error("hit: expected %0d actual %0d", exp_h.hit, hit_ch.data.hit);
                        failed = 1'b1;
                    end
                    if (hit_ch.data.zero_length !== exp_h.zero_length)
                    begin
                        $error("zero_length: expected %0d actual %0d",
                               exp_h.zero_length, hit_ch.data.zero_length);
                        failed = 1'b1;
                    end
                    if (hit_ch.data.closest_x !== exp_h.closest_x)
                    begin
                        $error("closest_x: expected %0d actual %0d",
                               exp_h.closest_x, hit_ch.data.closest_x);
                        failed = 1'b1;
                    end
                    if (hit_ch.data.closest_y !== exp_h.closest_y)
                    begin
                        $error("closest_y: expected %0d actual %0d",
                               exp_h.closest_y, hit_ch.data.closest_y);
                        failed = 1'b1;
                    end
                end
            end
            hit_ch.ready <= quiet_phase || ($urandom_range(99) >= 24);
        end
    end

    // watchdog
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((seg_ch.valid && seg_ch.ready) || (hit_ch.valid && hit_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        failed      = 1'b0;
        quiet_phase = 1'b0;
        stall_pct   = 24;
        radius_q    = scct_pkg::RADIUS_RESET;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        seg_ch.valid = 1'b0;
        seg_ch.data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_radius_settings();
        test_random(100);
        drain();
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== segment_circle_collision_test.f =====
rtl/scct_pkg.sv
rtl/scct_if.sv
rtl/scct_divider.sv
rtl/segment_circle_collision_test.sv
tb/sv/scct_tb_if.sv
tb/sv/segment_circle_collision_test_tb.sv
